### hdl/rmsg_pkg.sv
`default_nettype none

package rmsg_pkg;

    localparam int SAMPLE_W         = 24;
    localparam int THR_W            = 23;
    localparam int THR2_W           = 2 * THR_W;
    localparam int SUM_W            = 58;
    localparam int GATE_W           = 16;
    localparam int DECAY_W          = 15;

    localparam int MAX_BLOCK_DEF    = 4096;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam logic [THR_W-1:0]   THR_RESET  = THR_W'(83886);
    localparam logic [THR2_W-1:0]  THR2_RESET = THR2_W'(46'd83886 * 46'd83886);
    localparam logic [GATE_W-1:0]  GATE_ONE   = GATE_W'(32768);
    localparam logic [GATE_W-1:0]  GATE_FLOOR = GATE_W'(328);
    localparam logic [DECAY_W-1:0] DECAY_Q15  = DECAY_W'(32636);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_block;
    } in_item_t;

    typedef struct packed {
        logic [GATE_W-1:0] gate_value;
        logic              gate_opened;
    } out_item_t;

endpackage

`default_nettype wire

### hdl/block_rms_noise_gate.sv
`default_nettype none

// RMS noise gate. Send signed Q1.23 samples on the input channel, one transfer
// per clock at full rate, and mark the final sample of each block with
// last_in_block; each such sample yields one result transfer carrying the new
// Q1.15 gate gain and whether the block RMS exceeded the configured threshold. The
// result passes through registered steps after the last sample is taken: the
// square is registered on the taking edge, then add and block latch,
// threshold-times-count partial products, and compare and gate update. Input is
// only held off when a result is still waiting downstream and the small
// block-end pipeline behind it is full. The threshold register is taken on
// every cycle; its square is registered in the cycle after a write, still
// ahead of any block that ends with a sample taken on or after the write edge.
module block_rms_noise_gate #(
    parameter int MAX_BLOCK   = rmsg_pkg::MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = rmsg_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire rmsg_pkg::in_item_t         in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output rmsg_pkg::out_item_t             out_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [rmsg_pkg::THR_W-1:0] cfg_data
);
    import rmsg_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    logic [THR_W-1:0] thr_reg;
    logic             blk_valid;
    logic             blk_ready;
    logic [SUM_W-1:0] blk_sum;
    logic [CNT_W-1:0] blk_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    rmsg_accum #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_sum   (blk_sum),
        .blk_count (blk_count)
    );

    rmsg_decide #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .thr       (thr_reg),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_sum   (blk_sum),
        .blk_count (blk_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### hdl/rmsg_accum.sv
`default_nettype none

module rmsg_accum #(
    parameter int MAX_BLOCK   = rmsg_pkg::MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = rmsg_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire rmsg_pkg::in_item_t               in_data,
    output logic                                  blk_valid,
    input  wire logic                             blk_ready,
    output logic [rmsg_pkg::SUM_W-1:0]            blk_sum,
    output logic [$clog2(MAX_BLOCK + 1)-1:0]      blk_count
);
    import rmsg_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SQ_W  = 2 * SAMPLE_BITS;

    logic                   sq_valid_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic                   sq_last_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   blk_valid_reg;
    logic [SUM_W-1:0]       blk_sum_reg;
    logic [CNT_W-1:0]       blk_cnt_reg;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_W-1:0]        sq_next;
    logic [SUM_W:0]         sum_add;
    logic [SUM_W-1:0]       sum_next;
    logic [CNT_W-1:0]       cnt_next;
    logic                   blk_free;
    logic                   sq_take;
    logic                   in_take;

    assign raw      = in_data.sample[SAMPLE_BITS-1:0];
    assign mag      = raw[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - raw) : raw;
    assign sq_next  = SQ_W'(mag) * SQ_W'(mag);

    assign sum_add  = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
    assign sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign cnt_next = (cnt_reg < CNT_W'(MAX_BLOCK)) ? cnt_reg + CNT_W'(1) : cnt_reg;

    assign blk_free = !blk_valid_reg || blk_ready;
    assign sq_take  = sq_valid_reg && (!sq_last_reg || blk_free);
    assign in_ready = !sq_valid_reg || sq_take;
    assign in_take  = in_valid && in_ready;

    assign blk_valid = blk_valid_reg;
    assign blk_sum   = blk_sum_reg;
    assign blk_count = blk_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                sq_valid_reg <= 1'b1;
            else if (sq_take)
                sq_valid_reg <= 1'b0;

            if (sq_take && sq_last_reg)
            begin
                sum_reg       <= '0;
                cnt_reg       <= '0;
                blk_valid_reg <= 1'b1;
            end
            else
            begin
                if (sq_take)
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                end
                if (blk_ready)
                    blk_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sq_reg      <= sq_next;
            sq_last_reg <= in_data.last_in_block;
        end
        if (sq_take && sq_last_reg)
        begin
            blk_sum_reg <= sum_next;
            blk_cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hdl/rmsg_decide.sv
`default_nettype none

module rmsg_decide #(
    parameter int MAX_BLOCK = rmsg_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [rmsg_pkg::THR_W-1:0]       thr,
    input  wire logic                             blk_valid,
    output logic                                  blk_ready,
    input  wire logic [rmsg_pkg::SUM_W-1:0]       blk_sum,
    input  wire logic [$clog2(MAX_BLOCK + 1)-1:0] blk_count,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output rmsg_pkg::out_item_t                   out_data
);
    import rmsg_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int PP_W  = THR_W + CNT_W;
    localparam int LIM_W = THR2_W + CNT_W;
    localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;
    localparam int PRD_W = GATE_W + DECAY_W;

    logic [THR2_W-1:0]  thr2_reg;
    logic               p_valid_reg;
    logic [SUM_W-1:0]   p_sum_reg;
    logic [PP_W-1:0]    pp_hi_reg;
    logic [PP_W-1:0]    pp_lo_reg;
    logic [GATE_W-1:0]  gate_reg;
    logic               res_valid_reg;
    out_item_t          res_reg;

    logic [PP_W-1:0]    pp_hi_next;
    logic [PP_W-1:0]    pp_lo_next;
    logic [CMP_W-1:0]   limit;
    logic               opened;
    logic [PRD_W-1:0]   decay_prod;
    logic [GATE_W-1:0]  gate_next;
    logic               res_free;
    logic               p_take;
    logic               blk_take;

    assign pp_hi_next = PP_W'(thr2_reg[THR2_W-1:THR_W]) * PP_W'(blk_count);
    assign pp_lo_next = PP_W'(thr2_reg[THR_W-1:0]) * PP_W'(blk_count);

    assign limit      = (CMP_W'(pp_hi_reg) << THR_W) + CMP_W'(pp_lo_reg);
    assign opened     = CMP_W'(p_sum_reg) > limit;
    assign decay_prod = PRD_W'(gate_reg) * PRD_W'(DECAY_Q15);

    always_comb
    begin
        if (opened)
            gate_next = GATE_ONE;
        else if (gate_reg >= GATE_FLOOR)
            gate_next = decay_prod[PRD_W-1:DECAY_W];
        else
            gate_next = gate_reg;
    end

    assign res_free  = !res_valid_reg || out_ready;
    assign p_take    = p_valid_reg && res_free;
    assign blk_ready = !p_valid_reg || res_free;
    assign blk_take  = blk_valid && blk_ready;

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr2_reg      <= THR2_RESET;
            p_valid_reg   <= 1'b0;
            gate_reg      <= GATE_ONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            thr2_reg <= THR2_W'(thr) * THR2_W'(thr);

            if (blk_take)
                p_valid_reg <= 1'b1;
            else if (p_take)
                p_valid_reg <= 1'b0;

            if (p_take)
            begin
                gate_reg      <= gate_next;
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_take)
        begin
            p_sum_reg <= blk_sum;
            pp_hi_reg <= pp_hi_next;
            pp_lo_reg <= pp_lo_next;
        end
        if (p_take)
        begin
            res_reg.gate_value  <= gate_next;
            res_reg.gate_opened <= opened;
        end
    end

endmodule

`default_nettype wire

### test/block_rms_noise_gate_test.sv
`timescale 1ns / 1ps

module block_rms_noise_gate_test;

    import rmsg_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASES       = 7;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    in_item_t            in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [THR_W-1:0]    cfg_data  = '0;

    block_rms_noise_gate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // gate model state
    logic [SUM_W-1:0]  sum_model   = '0;
    logic [12:0]       count_model = '0;
    logic [GATE_W-1:0] gate_model  = GATE_ONE;
    logic [THR_W-1:0]  thr_model   = THR_RESET;
    out_item_t         pending_gates[$];

    int          fail_count  = 0;
    int          idle_cycles = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    bit          gaps_off    = 1'b0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    int          run_left    = 0;
    logic        run_ready   = 1'b1;
    out_item_t   want_gate;

    function automatic void accumulate_sample(input in_item_t item);
        logic [SAMPLE_W-1:0]   mag;
        logic [2*SAMPLE_W-1:0] sq;
        logic [THR2_W-1:0]     thr2;
        logic [63:0]           bound;
        logic [31:0]           decayed;
        logic                  opened;
        out_item_t             res;
        mag = item.sample;
        if (item.sample[SAMPLE_W-1])
            mag = ~mag + 1'b1;
        sq = mag * mag;
        if (sum_model > {SUM_W{1'b1}} - sq)
            sum_model = {SUM_W{1'b1}};
        else
            sum_model = sum_model + sq;
        if (count_model < MAX_BLOCK_DEF)
            count_model = count_model + 1'b1;
        if (item.last_in_block)
        begin
            thr2 = thr_model * thr_model;
            bound = thr2 * count_model;
            opened = 64'(sum_model) > bound;
            if (opened)
                gate_model = GATE_ONE;
            else if (gate_model >= GATE_FLOOR)
            begin
                decayed = gate_model * DECAY_Q15;
                gate_model = GATE_W'(decayed >> 15);
            end
            res.gate_value = gate_model;
            res.gate_opened = opened;
            pending_gates.push_back(res);
            sum_model = '0;
            count_model = '0;
        end
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
        in_item_t item;
        int       gap;
        item.sample = s;
        item.last_in_block = last;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
        end
        burst_left--;
        if (gaps_off)
            gap = 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_sample(item);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_gates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        thr_model = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_level_block(input int len, input int unsigned level, input bit noise);
        int v;
        for (int i = 0; i < len; i++)
        begin
            if (noise)
                v = int'($urandom());
            else if ($urandom_range(0, 3) == 0)
                v = $urandom_range(0, 1) ? int'(level) : -int'(level);
            else
                v = int'($urandom_range(0, 2 * level)) - int'(level);
            send_sample(SAMPLE_W'(v), i == len - 1);
        end
    endtask

    task automatic test_reset_threshold();
        send_sample(24'sd83886, 1'b1);
        send_sample(24'sd83887, 1'b1);
        send_sample(-24'sd83886, 1'b1);
        send_sample(-24'sd83887, 1'b1);
        send_sample(24'sd83886, 1'b0);
        send_sample(-24'sd83886, 1'b0);
        send_sample(24'sd83886, 1'b1);
        send_sample(24'sd0, 1'b0);
        send_sample(24'sd200000, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_sample(24'sh7FFFFF, 1'b1);
        send_sample(24'sh800000, 1'b1);
        send_sample(24'sd0, 1'b1);
        send_sample(-24'sd1, 1'b1);
        send_sample(24'sd1, 1'b1);
        send_sample(24'sh555555, 1'b0);
        send_sample(24'shAAAAAA, 1'b1);
    endtask

    task automatic test_threshold_edges();
        write_threshold('0);
        send_sample(24'sd0, 1'b1);
        send_sample(24'sd1, 1'b1);
        send_sample(-24'sd1, 1'b1);
        write_threshold({THR_W{1'b1}});
        send_sample(24'sh800000, 1'b1);
        send_sample(24'sh7FFFFF, 1'b1);
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(24'sh800000, 1'b1);
    endtask

    task automatic test_release_floor();
        write_threshold({THR_W{1'b1}});
        send_sample(24'sh800000, 1'b1);
        while (gate_model >= GATE_FLOOR)
            send_sample(24'sd0, 1'b1);
        repeat (6) send_sample(SAMPLE_W'(int'($urandom_range(0, 8388607))), 1'b1);
        send_sample(24'sh800000, 1'b1);
    endtask

    task automatic test_saturation();
        // saturate sum and count in one full-scale block; both decide the outcome
        write_threshold({THR_W{1'b1}});
        for (int i = 0; i < 4100; i++)
            send_sample(24'sh800000, i == 4099);
    endtask

    task automatic test_backpressure();
        write_threshold(THR_W'($urandom_range(0, 8388607)));
        hold_req = 1'b1;
        gaps_off = 1'b1;
        repeat (60) send_sample(SAMPLE_W'($urandom()), 1'b1);
        gaps_off = 1'b0;
        drain_results();
        repeat (20) send_sample(SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)));
        send_sample(SAMPLE_W'($urandom()), 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [THR_W-1:0] thr;
        int               len;
        int               r;
        longint unsigned  level;
        int               stop_at;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: thr = THR_RESET;
                1: thr = '0;
                2: thr = {THR_W{1'b1}};
                3: thr = THR_W'($urandom_range(1, 1000));
                4: thr = THR_W'($urandom_range(1000, 100000));
                5: thr = THR_W'(1);
                default: thr = THR_W'($urandom());
            endcase
            write_threshold(thr);
            stop_at = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < stop_at)
            begin
                r = $urandom_range(0, 19);
                if (r < 16)
                    len = $urandom_range(1, 8);
                else if (r < 19)
                    len = $urandom_range(9, 64);
                else
                    len = $urandom_range(65, 300);
                if (thr == 0)
                    level = $urandom_range(0, 3);
                else
                    level = longint'(thr) * $urandom_range(0, 300) / 100;
                if (level > 8388607)
                    level = 8388607;
                send_level_block(len, int'(level), $urandom_range(0, 4) == 0);
            end
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (run_left == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        run_ready = 1'b1;
                        run_left = $urandom_range(50, 150);
                    end
                    2, 3, 4, 5:
                    begin
                        run_ready = 1'b1;
                        run_left = $urandom_range(1, 12);
                    end
                    default:
                    begin
                        run_ready = 1'b0;
                        run_left = $urandom_range(1, 10);
                    end
                endcase
            end
            run_left--;
            out_ready <= run_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_gates.size() == 0)
            begin
                $error("gate result %h with none expected", out_data);
                fail_count++;
            end
            else
            begin
                want_gate = pending_gates.pop_front();
                if (out_data.gate_value !== want_gate.gate_value)
                begin
                    $error("gate_value: expected %0d, actual %0d",
                           want_gate.gate_value, out_data.gate_value);
                    fail_count++;
                end
                if (out_data.gate_opened !== want_gate.gate_opened)
                begin
                    $error("gate_opened: expected %0d, actual %0d",
                           want_gate.gate_opened, out_data.gate_opened);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_threshold();
        test_field_extremes();
        test_threshold_edges();
        test_release_floor();
        test_saturation();
        test_backpressure();
        test_random_traffic();
        drain_results();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
